### rtl/msst_pkg.sv
// ----------------------------------------------------------------------------
// msst_pkg
// Shared types and codes for the multiset store.
// ----------------------------------------------------------------------------
package msst_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int KIND_W   = 2;
  localparam int CNT_OUT_W = 5;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_QUERY  = 2'd2,
    KIND_RSVD   = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2,
    STATUS_RSVD   = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

### rtl/msst_mem.sv
// ----------------------------------------------------------------------------
// msst_mem
// Entry storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msst_mem
  import msst_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int WIDTH = VALUE_WIDTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  mem_ctl_t         ctl,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/msst_ctrl.sv
// ----------------------------------------------------------------------------
// msst_ctrl
// Scan sequencer: walks the stored entries, counts matches, compacts on
// remove, appends on add, and issues the result word.
// ----------------------------------------------------------------------------
module msst_ctrl
  import msst_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int AW          = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int CW          = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_strobe,
  output logic [CNT_OUT_W-1:0]   out_count,
  output logic                   out_present,
  output logic [STATUS_W-1:0]    out_status,
  output logic [CNT_OUT_W-1:0]   out_fill,
  output mem_ctl_t               mem_ctl,
  output logic [AW-1:0]          mem_waddr,
  output logic [VALUE_WIDTH-1:0] mem_wdata,
  output logic [AW-1:0]          mem_raddr,
  input  logic [VALUE_WIDTH-1:0] mem_rdata
);

  localparam logic [CW-1:0] ONE  = CW'(1);
  localparam logic [CW-1:0] FULL = CW'(CAPACITY);

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [CW-1:0]          rd_r, rd_nxt;
  logic [CW-1:0]          wr_r, wr_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   pend_r, pend_nxt;
  kind_t                  kind_r, kind_nxt;
  logic [VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                   strobe_r, strobe_nxt;
  logic [CNT_OUT_W-1:0]   count_r, count_nxt;
  logic                   present_r, present_nxt;
  status_t                status_r, status_nxt;
  logic [CNT_OUT_W-1:0]   ofill_r, ofill_nxt;
  logic                   rd_go;
  logic [CW+CNT_OUT_W-1:0] cnt_ext, fill_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      pend_r   <= pend_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_r      <= rd_nxt;
    wr_r      <= wr_nxt;
    cnt_r     <= cnt_nxt;
    kind_r    <= kind_nxt;
    val_r     <= val_nxt;
    count_r   <= count_nxt;
    present_r <= present_nxt;
    status_r  <= status_nxt;
    ofill_r   <= ofill_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    rd_nxt      = rd_r;
    wr_nxt      = wr_r;
    cnt_nxt     = cnt_r;
    pend_nxt    = 1'b0;
    kind_nxt    = kind_r;
    val_nxt     = val_r;
    strobe_nxt  = 1'b0;
    count_nxt   = count_r;
    present_nxt = present_r;
    status_nxt  = status_r;
    ofill_nxt   = ofill_r;
    mem_ctl     = '0;
    mem_waddr   = wr_r[AW-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = rd_r[AW-1:0];
    rd_go       = 1'b0;
    cnt_ext     = '0;
    fill_ext    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          kind_nxt  = kind_t'(in_kind);
          val_nxt   = in_value;
          rd_nxt    = '0;
          wr_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_go = (rd_r < fill_r);
        if (rd_go) begin
          mem_ctl.re = 1'b1;
          rd_nxt     = rd_r + ONE;
        end
        pend_nxt = rd_go;
        if (pend_r) begin
          if (mem_rdata == val_r) begin
            cnt_nxt = cnt_r + ONE;
          end else begin
            // survivors move down over removed copies
            if (kind_r == KIND_REMOVE) begin
              mem_ctl.we = 1'b1;
            end
            wr_nxt = wr_r + ONE;
          end
        end
        if (!rd_go && !pend_r) begin
          status_nxt = STATUS_OK;
          unique case (kind_r)
            KIND_ADD: begin
              if (fill_r == FULL) begin
                status_nxt = STATUS_FULL;
              end else begin
                mem_ctl.we = 1'b1;
                mem_waddr  = fill_r[AW-1:0];
                mem_wdata  = val_r;
                fill_nxt   = fill_r + ONE;
              end
            end
            KIND_REMOVE: begin
              if (cnt_r == '0) begin
                status_nxt = STATUS_ABSENT;
              end else begin
                fill_nxt = wr_r;
              end
            end
            default: begin
            end
          endcase
          cnt_ext     = {{CNT_OUT_W{1'b0}}, cnt_r};
          fill_ext    = {{CNT_OUT_W{1'b0}}, fill_nxt};
          count_nxt   = cnt_ext[CNT_OUT_W-1:0];
          ofill_nxt   = fill_ext[CNT_OUT_W-1:0];
          present_nxt = (cnt_r != '0);
          strobe_nxt  = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != ST_IDLE);
  assign out_strobe  = strobe_r;
  assign out_count   = count_r;
  assign out_present = present_r;
  assign out_status  = status_r;
  assign out_fill    = ofill_r;

endmodule

### rtl/multiset_store.sv
// ----------------------------------------------------------------------------
// multiset_store
// Bounded multiset of values held packed in one memory with a fill count.
//
//   channel  ports                                   handshake
//   input    in_kind, in_value                       start & !busy
//   result   out_count, out_present, out_status,     out_strobe, one cycle
//            out_fill
//
// An operation scans the stored entries between accept and result strobe:
// the scan reads one entry a cycle through the memory read port, and the
// final cycle appends or settles the compacted fill.
// Reset clears the fill count, state and strobe, not the entries; entries are read only below the fill count.
// The result strobe is high for one cycle and the result fields hold until the next result; the receiver cannot stall.
// ----------------------------------------------------------------------------
module multiset_store
  import msst_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [KIND_W-1:0]      in_kind,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_strobe,
  output logic [CNT_OUT_W-1:0]   out_count,
  output logic                   out_present,
  output logic [STATUS_W-1:0]    out_status,
  output logic [CNT_OUT_W-1:0]   out_fill
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  mem_ctl_t               mem_ctl;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_raddr;
  logic [VALUE_WIDTH-1:0] mem_wdata;
  logic [VALUE_WIDTH-1:0] mem_rdata;

  msst_ctrl #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_value    (in_value),
    .out_strobe  (out_strobe),
    .out_count   (out_count),
    .out_present (out_present),
    .out_status  (out_status),
    .out_fill    (out_fill),
    .mem_ctl     (mem_ctl),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  msst_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
